### rtl/core/kpd_pkg.sv
// kpd_pkg: shared types and constants of the k-mer profile distance block.
// Holds the item and result structs, command and status codes, and register
// map. No dependencies.
package kpd_pkg;

	// Configuration register map
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_IDX_KMER_LEN = 1'b0;
	localparam logic [2:0] KMER_LEN_RESET = 3'd6;

	// Commands
	localparam logic [1:0] CMD_APPEND_A = 2'd0;
	localparam logic [1:0] CMD_APPEND_B = 2'd1;
	localparam logic [1:0] CMD_COMPARE  = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	// Nucleotide characters and their 2-bit codes
	localparam logic [7:0] ASCII_A = 8'h41;
	localparam logic [7:0] ASCII_C = 8'h43;
	localparam logic [7:0] ASCII_G = 8'h47;
	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	// Fixed-point format of the distance
	localparam int unsigned FRAC_W = 16;
	localparam logic [16:0] DIST_ONE = 17'h10000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] base;
	} item_t;

	typedef struct packed {
		logic [16:0] distance_q16;
		logic [15:0] shared_count;
		logic [15:0] norm_count;
		logic [1:0]  status;
	} result_t;

endpackage

### rtl/core/kmer_profile_distance.sv
// kmer_profile_distance: top level of the k-mer profile distance block.
// Depends on kpd_pkg, kpd_ram (histogram memories) and kpd_div (quotient).
//
// Bases for sequence A or B arrive as items; each is coded A/C/G/T, shifted
// into that sequence's window of kmer_len bases, and once the window is full
// the matching bin of the sequence's histogram (one synchronous RAM per
// sequence, 4^MAX_K counters of COUNT_WIDTH bits) is incremented by a
// read-modify-write. Appends run at one item per cycle: the read is issued
// in the accept cycle, the write follows in the next cycle, and the last write
// is forwarded when the next append hits the same bin. A compare item walks
// every bin once, summing the per-bin minimum and writing zeros back, then
// runs a one-bit-per-cycle divider of COUNT_WIDTH + 16 steps for
// round(shared*65536/norm), and no item is taken until the result is
// loaded into the result register. Appends are taken again while the result
// still waits to be read out. After reset the block clears every bin of
// both histograms before it takes its first item (configuration writes are
// taken throughout).
module kmer_profile_distance #(
	parameter int unsigned MAX_K       = 6,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item channel
	input  logic                      item_valid,
	output logic                      item_ready,
	input  kpd_pkg::item_t            item,
	// result channel
	output logic                      result_valid,
	input  logic                      result_ready,
	output kpd_pkg::result_t          result,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [kpd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int unsigned CW    = COUNT_WIDTH;
	localparam int unsigned AW    = 2 * MAX_K;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned DW    = CW + kpd_pkg::FRAC_W;
	localparam logic [3:0]  MAX_K_K = 4'(MAX_K);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAIN,
		ST_SWEEP,
		ST_TAIL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration and sequence state
	logic [2:0]    kmer_len_q;
	logic [AW-1:0] win_a_q, win_b_q;
	logic [CW-1:0] len_a_q, len_b_q;
	logic          ovf_q;

	// compare bookkeeping
	logic [AW-1:0] cnt_q;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] norm_q;
	logic          short_q;
	logic          ovf_cmp_q;
	logic          div_start_q;

	// append pipeline: read issued at accept, write in stage 1
	logic          app_s1;
	logic          sel_s1;
	logic [AW-1:0] addr_s1;
	// last append write, forwarded to the next read of the same bin
	logic          lw_valid_q;
	logic          lw_sel_q;
	logic [AW-1:0] lw_addr_q;
	logic [CW-1:0] lw_data_q;
	// sweep pipeline
	logic          sw_s1;
	logic [AW-1:0] sw_addr_s1;

	logic             result_valid_q;
	kpd_pkg::result_t result_q;

	// combinational
	logic          accept;
	logic          sel_b;
	logic [3:0]    eff_k;
	logic [CW-1:0] k_cw;
	logic [AW-1:0] mask;
	logic [1:0]    code;
	logic [AW-1:0] win_cur, win_next;
	logic [CW-1:0] len_cur, len_next;
	logic          len_full;
	logic          hit;
	logic [CW-1:0] tot_a, tot_b, norm_c;

	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [CW-1:0] wdata;
	logic          we_a, we_b;
	logic          zero_we;
	logic [CW-1:0] rdata_a, rdata_b;
	logic          fwd;
	logic [CW-1:0] app_old, app_new;
	logic [CW-1:0] min_ab;

	logic [DW-1:0] dividend;
	logic          div_done;
	logic [DW-1:0] quotient;

	logic [CW+15:0]   acc_ext, norm_ext;
	logic [15:0]      acc_sat, norm_sat;
	kpd_pkg::result_t res_c;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign sel_b      = (item.cmd == kpd_pkg::CMD_APPEND_B);

	// Clamp the k register into 1..MAX_K
	always_comb begin
		if (kmer_len_q == 3'd0) begin
			eff_k = 4'd1;
		end else if ({1'b0, kmer_len_q} > MAX_K_K) begin
			eff_k = MAX_K_K;
		end else begin
			eff_k = {1'b0, kmer_len_q};
		end
	end
	assign k_cw = CW'(eff_k);

	always_comb begin
		for (int i = 0; i < AW; i++) begin
			mask[i] = (5'(i) < {eff_k, 1'b0});
		end
	end

	always_comb begin
		case (item.base)
			kpd_pkg::ASCII_A: code = kpd_pkg::CODE_A;
			kpd_pkg::ASCII_C: code = kpd_pkg::CODE_C;
			kpd_pkg::ASCII_G: code = kpd_pkg::CODE_G;
			default:          code = kpd_pkg::CODE_T;
		endcase
	end

	// Window update, length count and full-window test for an append
	assign win_cur  = sel_b ? win_b_q : win_a_q;
	assign len_cur  = sel_b ? len_b_q : len_a_q;
	assign len_full = &len_cur;
	assign win_next = (AW'({win_cur, 2'b00}) | AW'(code)) & mask;
	assign len_next = len_cur + 1'b1;
	assign hit      = (len_next >= k_cw);

	// k-mer totals; the smaller one normalises the shared count
	assign tot_a  = (len_a_q >= k_cw) ? (len_a_q - k_cw + 1'b1) : '0;
	assign tot_b  = (len_b_q >= k_cw) ? (len_b_q - k_cw + 1'b1) : '0;
	assign norm_c = (tot_a < tot_b) ? tot_a : tot_b;

	// Memory port steering: appends and zero writes never overlap
	assign raddr   = (state_q == ST_SWEEP) ? cnt_q : win_next;
	assign fwd     = lw_valid_q && (lw_sel_q == sel_s1) && (lw_addr_q == addr_s1);
	assign app_old = fwd ? lw_data_q : (sel_s1 ? rdata_b : rdata_a);
	assign app_new = app_old + 1'b1;
	assign zero_we = (state_q == ST_CLEAR) || sw_s1;
	assign we_a    = (app_s1 && !sel_s1) || zero_we;
	assign we_b    = (app_s1 && sel_s1) || zero_we;
	assign waddr   = app_s1 ? addr_s1 : ((state_q == ST_CLEAR) ? cnt_q : sw_addr_s1);
	assign wdata   = app_s1 ? app_new : '0;
	assign min_ab  = (rdata_a < rdata_b) ? rdata_a : rdata_b;

	kpd_ram #(
		.WIDTH (CW),
		.DEPTH (DEPTH)
	) u_hist_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_a)
	);

	kpd_ram #(
		.WIDTH (CW),
		.DEPTH (DEPTH)
	) u_hist_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_b)
	);

	// Rounded quotient: (shared * 2^16 + norm/2) / norm
	assign dividend = {acc_q, {kpd_pkg::FRAC_W{1'b0}}} + DW'(norm_q >> 1);

	kpd_div #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend),
		.divisor  (norm_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Saturate counts into the 16-bit result fields
	assign acc_ext  = (CW + 16)'(acc_q);
	assign norm_ext = (CW + 16)'(norm_q);
	assign acc_sat  = (|acc_ext[CW+15:16]) ? 16'hFFFF : acc_ext[15:0];
	assign norm_sat = (|norm_ext[CW+15:16]) ? 16'hFFFF : norm_ext[15:0];

	always_comb begin
		res_c.norm_count = norm_sat;
		if (short_q) begin
			res_c.distance_q16 = kpd_pkg::DIST_ONE;
			res_c.shared_count = '0;
			res_c.status       = kpd_pkg::STATUS_SHORT;
		end else begin
			res_c.shared_count = acc_sat;
			res_c.status       = ovf_cmp_q ? kpd_pkg::STATUS_OVERFLOW : kpd_pkg::STATUS_OK;
			// shared at or above norm, or a quotient rounding up to one: distance 0
			if (acc_q >= norm_q || (|quotient[DW-1:16])) begin
				res_c.distance_q16 = '0;
			end else begin
				res_c.distance_q16 = kpd_pkg::DIST_ONE - {1'b0, quotient[15:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			kmer_len_q     <= kpd_pkg::KMER_LEN_RESET;
			win_a_q        <= '0;
			win_b_q        <= '0;
			len_a_q        <= '0;
			len_b_q        <= '0;
			ovf_q          <= 1'b0;
			cnt_q          <= '0;
			acc_q          <= '0;
			norm_q         <= '0;
			short_q        <= 1'b0;
			ovf_cmp_q      <= 1'b0;
			div_start_q    <= 1'b0;
			app_s1         <= 1'b0;
			sel_s1         <= 1'b0;
			addr_s1        <= '0;
			lw_valid_q     <= 1'b0;
			lw_sel_q       <= 1'b0;
			lw_addr_q      <= '0;
			lw_data_q      <= '0;
			sw_s1          <= 1'b0;
			sw_addr_s1     <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			div_start_q <= 1'b0;
			app_s1      <= 1'b0;
			sw_s1       <= 1'b0;
			// remember this cycle's append write for forwarding
			lw_valid_q  <= app_s1;
			lw_sel_q    <= sel_s1;
			lw_addr_q   <= addr_s1;
			lw_data_q   <= app_new;

			if (psel && penable && pwrite && (paddr[2] == kpd_pkg::REG_IDX_KMER_LEN)) begin
				kmer_len_q <= pwdata[2:0];
			end

			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end

			// accumulate the per-bin minimum as sweep reads return
			if (sw_s1) begin
				acc_q <= acc_q + min_ab;
			end

			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (item.cmd)
							kpd_pkg::CMD_APPEND_A, kpd_pkg::CMD_APPEND_B: begin
								if (len_full) begin
									// drop the base, flag it for the next compare
									ovf_q <= 1'b1;
								end else begin
									if (sel_b) begin
										win_b_q <= win_next;
										len_b_q <= len_next;
									end else begin
										win_a_q <= win_next;
										len_a_q <= len_next;
									end
									app_s1  <= hit;
									sel_s1  <= sel_b;
									addr_s1 <= win_next;
								end
							end
							kpd_pkg::CMD_COMPARE: begin
								norm_q    <= norm_c;
								short_q   <= (norm_c == '0);
								ovf_cmp_q <= ovf_q;
								acc_q     <= '0;
								win_a_q   <= '0;
								win_b_q   <= '0;
								len_a_q   <= '0;
								len_b_q   <= '0;
								ovf_q     <= 1'b0;
								state_q   <= ST_DRAIN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DRAIN: begin
					// let the last append write land before the sweep reads
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					sw_s1      <= 1'b1;
					sw_addr_s1 <= cnt_q;
					cnt_q      <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result register is free
					if (!result_valid_q || result_ready) begin
						result_q       <= res_c;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[2] == kpd_pkg::REG_IDX_KMER_LEN) ? 32'(kmer_len_q) : 32'h0;

endmodule

### rtl/core/kpd_ram.sv
// kpd_ram: generic single-write, single-read synchronous RAM.
// Read data is registered and returns the old contents on a same-address
// write. No dependencies.
module kpd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/kpd_div.sv
// kpd_div: restoring unsigned divider, one quotient bit per cycle.
// Used for the shared-fraction quotient. No package dependencies.
module kpd_div #(
	parameter int unsigned CW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CW+15:0]   dividend,
	input  logic [CW-1:0]    divisor,
	output logic             done,
	output logic [CW+15:0]   quotient
);

	localparam int unsigned DW = CW + 16;
	localparam int unsigned CNT_W = $clog2(DW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

	logic [CW:0]      rem_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CW:0]      rem_sh;
	logic             ge;

	// shift one dividend bit into the partial remainder and try to subtract
	assign rem_sh = {rem_q[CW-1:0], quo_q[DW-1]};
	assign ge = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule
